### rtl/phase_broadcast_dedup_tracker_core_assert.svh
// Assertion macros for the phase broadcast tracker.
`ifndef PHASE_BROADCAST_DEDUP_TRACKER_CORE_ASSERT_SVH
`define PHASE_BROADCAST_DEDUP_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbdt_pkg.sv
// Types, constants and helpers shared by the phase broadcast tracker.
package pbdt_pkg;

  localparam logic [7:0] PHASE_UNSET     = 8'd255;
  localparam logic [7:0] LABEL_UNSET     = 8'd255;
  localparam logic [7:0] PHASE_BLACKHOLE = 8'd1;
  localparam logic [7:0] PHASE_WORMHOLE  = 8'd2;
  localparam logic [7:0] PHASE_COOLDOWN  = 8'd3;
  localparam logic [7:0] PHASE_TERMINATE = 8'd4;
  localparam logic [7:0] LABEL_BASELINE  = 8'd0;
  localparam logic [7:0] LABEL_BLACKHOLE = 8'd1;
  localparam logic [7:0] LABEL_WORMHOLE  = 8'd2;

  localparam logic [7:0] PREPARE_CODE_RST = 8'd5;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    MODE_PKT  = 2'd0,
    MODE_TICK = 2'd1,
    MODE_REQ  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    END_NONE     = 2'd0,
    END_ALREADY  = 2'd1,
    END_COMPLETE = 2'd2,
    END_CUT      = 2'd3
  } end_status_e;

  typedef enum logic [1:0] {
    CFG_MAGIC = 2'd0,
    CFG_PREP  = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_KEEP  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  prepare_code;
    logic [31:0] cooldown_limit_ticks;
    logic        keep_running;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pkt_magic;
    logic        pkt_long_enough;
    logic [31:0] pkt_session;
    logic [31:0] pkt_seq;
    logic [7:0]  pkt_phase;
  } item_t;

  typedef struct packed {
    logic [31:0] session;
    logic [31:0] seq;
    logic [7:0]  phase;
    logic [7:0]  label;
    logic [31:0] ticks;
    logic        prepare;
    logic        ended;
    logic        timeout;
    logic        request;
    logic        complete;
    logic        alive;
  } state_t;

  typedef struct packed {
    logic        forward_data;
    logic        applied;
    logic [7:0]  phase_now;
    logic [7:0]  label_now;
    logic [31:0] last_sequence;
    logic        prepare_seen;
    logic        run_ended;
    logic        ended_by_timeout;
    logic        ended_by_request;
    logic        ended_complete;
    logic [1:0]  end_status;
    logic        listener_alive;
  } result_t;

  function automatic logic [7:0] label_of(input logic [7:0] code);
    logic [7:0] lbl;
    lbl = LABEL_BASELINE;
    if (code == PHASE_BLACKHOLE) lbl = LABEL_BLACKHOLE;
    else if (code == PHASE_WORMHOLE) lbl = LABEL_WORMHOLE;
    return lbl;
  endfunction

endpackage

### rtl/pbdt_cfg.sv
// Configuration registers of the phase broadcast tracker.
module pbdt_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [1:0]       idx_i,
  input  logic [31:0]      data_i,
  output pbdt_pkg::cfg_t   cfg_o
);
  import pbdt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word           <= '0;
      cfg_q.prepare_code         <= PREPARE_CODE_RST;
      cfg_q.cooldown_limit_ticks <= '0;
      cfg_q.keep_running         <= 1'b0;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_MAGIC: cfg_q.magic_word           <= data_i;
        CFG_PREP:  cfg_q.prepare_code         <= data_i[7:0];
        CFG_LIMIT: cfg_q.cooldown_limit_ticks <= data_i;
        CFG_KEEP:  cfg_q.keep_running         <= data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/pbdt_step.sv
// Next-state and result logic for one item of the phase broadcast tracker.
module pbdt_step (
  input  pbdt_pkg::item_t   item_i,
  input  pbdt_pkg::cfg_t    cfg_i,
  input  pbdt_pkg::state_t  st_i,
  output pbdt_pkg::state_t  st_o,
  output pbdt_pkg::result_t res_o
);
  import pbdt_pkg::*;

  state_t      st;
  logic        fwd;
  logic        applied;
  end_status_e status;
  logic        bcast;
  logic        sess_ok;
  logic [31:0] ticks_inc;

  always_comb begin
    st        = st_i;
    fwd       = 1'b0;
    applied   = 1'b0;
    status    = END_NONE;
    bcast     = item_i.pkt_long_enough && (item_i.pkt_magic == cfg_i.magic_word);
    sess_ok   = 1'b1;
    ticks_inc = (st_i.ticks == '1) ? st_i.ticks : st_i.ticks + 32'd1;

    case (mode_e'(item_i.mode))
      MODE_PKT: begin
        if (st_i.alive) begin
          if (!bcast) begin
            fwd = cfg_i.keep_running || !st_i.ended;
          end else begin
            if (item_i.pkt_session != st_i.session) begin
              // a new root session: dropped once the run is over
              if (st_i.ended) begin
                sess_ok = 1'b0;
              end else begin
                st.session = item_i.pkt_session;
                st.seq     = '0;
                if (st_i.session != '0 && st_i.phase != PHASE_UNSET) begin
                  st.phase = PHASE_UNSET;
                  st.label = LABEL_UNSET;
                  st.ticks = '0;
                end
              end
            end
            if (sess_ok && item_i.pkt_seq > st.seq) begin
              st.seq = item_i.pkt_seq;
              if (item_i.pkt_phase == cfg_i.prepare_code) begin
                st.prepare = 1'b1;
                applied    = 1'b1;
              end else if (item_i.pkt_phase == PHASE_TERMINATE && st_i.ended) begin
                // late terminate copy records its sequence and stops the listener unless keep_running is set
                if (!cfg_i.keep_running) st.alive = 1'b0;
              end else begin
                if (item_i.pkt_phase != st.phase) st.ticks = '0;
                st.phase = item_i.pkt_phase;
                st.label = label_of(item_i.pkt_phase);
                applied  = 1'b1;
                if (item_i.pkt_phase == PHASE_TERMINATE) begin
                  st.ended = 1'b1;
                  if (!cfg_i.keep_running) st.alive = 1'b0;
                end
              end
            end
          end
        end
      end
      MODE_TICK: begin
        if (!st_i.ended) begin
          st.ticks = ticks_inc;
          if (st_i.phase == PHASE_COOLDOWN && ticks_inc > cfg_i.cooldown_limit_ticks) begin
            st.timeout = 1'b1;
            st.ended   = 1'b1;
          end
        end
      end
      MODE_REQ: begin
        if (st_i.ended) begin
          status = END_ALREADY;
        end else begin
          st.complete = (st_i.phase == PHASE_COOLDOWN);
          st.request  = 1'b1;
          st.ended    = 1'b1;
          status      = (st_i.phase == PHASE_COOLDOWN) ? END_COMPLETE : END_CUT;
        end
      end
      default: ;
    endcase
  end

  assign st_o = st;

  always_comb begin
    res_o.forward_data     = fwd;
    res_o.applied          = applied;
    res_o.phase_now        = st.phase;
    res_o.label_now        = st.label;
    res_o.last_sequence    = st.seq;
    res_o.prepare_seen     = st.prepare;
    res_o.run_ended        = st.ended;
    res_o.ended_by_timeout = st.timeout;
    res_o.ended_by_request = st.request;
    res_o.ended_complete   = st.complete;
    res_o.end_status       = status;
    res_o.listener_alive   = st.alive;
  end

endmodule

### rtl/phase_broadcast_dedup_tracker_core.sv
// Top level of the phase broadcast tracker: input register, tracker state, result register.
// Takes one item per clock cycle while the output is not stalled (packet header, tick or
// end-run request) and returns one result item for each. An item is first captured in an
// input register; when the output register is free or taken, the tracker state (session,
// sequence, phase, label, tick count and run flags) is updated and the result is loaded into
// the output register, which is held until taken. Output stalls reach s_axis_tready in the
// same cycle. Configuration writes take effect at once and are meant for idle periods.
module phase_broadcast_dedup_tracker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [31:0]                         cfg_data_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pkt_magic[31:0], pkt_long_enough[32], pkt_session[64:33], pkt_seq[96:65],
  // pkt_phase[104:97], zero fill [111:105]
  input  logic [pbdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                          s_axis_tuser,
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // forward_data[0], applied[1], phase_now[9:2], label_now[17:10], last_sequence[49:18],
  // prepare_seen[50], run_ended[51], ended_by_timeout[52], ended_by_request[53],
  // ended_complete[54], end_status[56:55], listener_alive[57], zero fill [63:58]
  output logic [pbdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import pbdt_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  state_t  st_q;
  state_t  st_d;
  result_t res_d;
  result_t res_q;
  logic    out_vld_q;
  logic    adv;

  pbdt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.mode            <= s_axis_tuser;
      in_q.pkt_magic       <= s_axis_tdata[31:0];
      in_q.pkt_long_enough <= s_axis_tdata[32];
      in_q.pkt_session     <= s_axis_tdata[64:33];
      in_q.pkt_seq         <= s_axis_tdata[96:65];
      in_q.pkt_phase       <= s_axis_tdata[104:97];
    end
  end

  pbdt_step u_step (
    .item_i (in_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.session  <= '0;
      st_q.seq      <= '0;
      st_q.phase    <= PHASE_UNSET;
      st_q.label    <= LABEL_UNSET;
      st_q.ticks    <= '0;
      st_q.prepare  <= 1'b0;
      st_q.ended    <= 1'b0;
      st_q.timeout  <= 1'b0;
      st_q.request  <= 1'b0;
      st_q.complete <= 1'b0;
      st_q.alive    <= 1'b1;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0,
                          res_q.listener_alive,
                          res_q.end_status,
                          res_q.ended_complete,
                          res_q.ended_by_request,
                          res_q.ended_by_timeout,
                          res_q.run_ended,
                          res_q.prepare_seen,
                          res_q.last_sequence,
                          res_q.label_now,
                          res_q.phase_now,
                          res_q.applied,
                          res_q.forward_data};

`include "phase_broadcast_dedup_tracker_core_assert.svh"

  `PBDT_ASSERT_NXT(a_ended_sticky, st_q.ended, st_q.ended, "run end flag cleared")
  `PBDT_ASSERT_NXT(a_stopped_sticky, !st_q.alive, !st_q.alive, "listener restarted")
  `PBDT_ASSERT_IMP(a_stop_needs_end, !st_q.alive, st_q.ended, "listener stopped before run end")
  `PBDT_ASSERT_IMP(a_cause_needs_end, st_q.timeout || st_q.request, st_q.ended,
                   "end cause set without run end")

endmodule
